/* sv/fractal_value_noise_2d_assert.svh */
// Assertion macros shared by the checker of the fractal value noise block.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef FRACTAL_VALUE_NOISE_2D_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_2D_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define FVN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define FVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fvn_pkg.sv */
// Shared types, constants and functions of the fractal value noise block.
// Used by the controller, the datapath, the hash pipeline and the top level.
package fvn_pkg;

  localparam int PRIME_SETS  = 10;
  localparam int SET_W       = 4;
  localparam int MAX_OCTAVES = 8;
  localparam int OCT_W       = 4;
  localparam int COS_ENTRIES = 1024;
  localparam int COS_IDX_W   = $clog2(COS_ENTRIES);
  localparam int VAL_W       = 18;
  localparam int SMO_W       = 19;
  localparam int SUM_W       = 23;
  localparam int PROD_W      = 38;
  localparam int ACC_W       = 24;
  localparam int AMP_W       = 17;
  localparam int OUT_W       = 21;
  localparam int OUT_LIMIT   = 524288;
  localparam logic [AMP_W-1:0] ONE_Q16 = 17'h10000;

  // Opcodes of an input word.
  localparam logic [1:0] OPC_RAW     = 2'd0;
  localparam logic [1:0] OPC_SMOOTH  = 2'd1;
  localparam logic [1:0] OPC_INTERP  = 2'd2;
  localparam logic [1:0] OPC_FRACTAL = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_TABLE_SELECT = 2'd0;
  localparam logic [1:0] REG_OCTAVE_BASE  = 2'd1;
  localparam logic [1:0] REG_NUM_OCTAVES  = 2'd2;
  localparam logic [1:0] REG_PERSISTENCE  = 2'd3;

  // Prime triples of the lattice hash.
  localparam logic [31:0] PRIME_A [PRIME_SETS] = '{
    32'd995615039, 32'd831731269, 32'd174329291, 32'd362489573, 32'd457025711,
    32'd787070341, 32'd405493717, 32'd458904767, 32'd531736441, 32'd997169939};
  localparam logic [31:0] PRIME_B [PRIME_SETS] = '{
    32'd600173719, 32'd162318869, 32'd946737083, 32'd795918041, 32'd880830799,
    32'd177340217, 32'd291031019, 32'd676625681, 32'd939683957, 32'd842027887};
  localparam logic [31:0] PRIME_C [PRIME_SETS] = '{
    32'd701464987, 32'd136250887, 32'd245679977, 32'd350777237, 32'd909678923,
    32'd593320781, 32'd391950901, 32'd424452397, 32'd810651871, 32'd423882827};

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_ROM, S_ISSUE, S_DRAIN, S_BLA, S_BLB, S_BLC, S_BLD, S_BLE,
    S_OCTM, S_OCTA, S_FINV, S_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NONE, DP_LOAD, DP_PREP, DP_ROM, DP_BLA, DP_BLB, DP_BLC, DP_BLD, DP_BLE,
    DP_OCTM, DP_OCTA, DP_FINV, DP_OUT
  } dp_op_t;

  // Tag that travels with a lattice point through the hash pipeline.
  typedef struct packed {
    logic       first;
    logic       last;
    logic [1:0] corner;
    logic [2:0] shift;
  } hash_tag_t;

  typedef struct packed {
    dp_op_t            op;
    logic              amp_step;
    logic [SET_W-1:0]  set;
    logic [2:0]        scale;
    logic              issue;
    logic signed [2:0] off_x;
    logic signed [2:0] off_y;
    hash_tag_t         tag;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_pending;
  } dp_stat_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic [2:0]        shift;
  } nb_info_t;

  typedef logic [AMP_W-1:0] cos_rom_t [COS_ENTRIES];

  // Reduce a value below twice the set count to a prime set index.
  function automatic logic [SET_W-1:0] mod_sets(logic [4:0] v);
    logic [4:0] r;
    r = (v >= 5'(PRIME_SETS)) ? v - 5'(PRIME_SETS) : v;
    return r[SET_W-1:0];
  endfunction

  // Offsets and smoothing weight (as a left shift) of one of nine neighbors.
  function automatic nb_info_t nb_info(logic [3:0] nb);
    nb_info_t r;
    unique case (nb)
      4'd0:    r = '{dx: -2'sd1, dy: -2'sd1, shift: 3'd0};
      4'd1:    r = '{dx:  2'sd0, dy: -2'sd1, shift: 3'd1};
      4'd2:    r = '{dx:  2'sd1, dy: -2'sd1, shift: 3'd0};
      4'd3:    r = '{dx: -2'sd1, dy:  2'sd0, shift: 3'd1};
      4'd4:    r = '{dx:  2'sd0, dy:  2'sd0, shift: 3'd2};
      4'd5:    r = '{dx:  2'sd1, dy:  2'sd0, shift: 3'd1};
      4'd6:    r = '{dx: -2'sd1, dy:  2'sd1, shift: 3'd0};
      4'd7:    r = '{dx:  2'sd0, dy:  2'sd1, shift: 3'd1};
      4'd8:    r = '{dx:  2'sd1, dy:  2'sd1, shift: 3'd0};
      default: r = '{dx:  2'sd0, dy:  2'sd0, shift: 3'd0};
    endcase
    return r;
  endfunction

  // Magnitude of a Q16.16 word.
  function automatic logic [31:0] mag32(logic [31:0] raw);
    return raw[31] ? (~raw + 32'd1) : raw;
  endfunction

  // Integer part, truncated toward zero, of a Q16.16 word scaled down by 2^s.
  function automatic logic [31:0] split_int(logic [31:0] raw, logic [2:0] s);
    logic [31:0] ip;
    ip = mag32(raw) >> (5'd16 + 5'(s));
    return raw[31] ? (32'd0 - ip) : ip;
  endfunction

  // Weight table index from the fraction magnitude of a scaled word.
  function automatic logic [COS_IDX_W-1:0] split_idx(logic [31:0] raw, logic [2:0] s);
    logic [31:0] m;
    m = mag32(raw) >> s;
    return m[15:16-COS_IDX_W];
  endfunction

  // One table entry: sin^2 of a quarter-wave angle in Q1.16, from a Q30 series.
  function automatic logic [AMP_W-1:0] cos_weight(int unsigned idx);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint unsigned sq;
    longint          s;
    a    = (64'd1686629713 * longint'(idx)) / COS_ENTRIES;
    a2   = (a * a) >> 30;
    term = a;
    s    = longint'(a);
    for (int k = 1; k <= 6; k++) begin
      term = (term * a2) >> 30;
      unique case (k)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        default: term = term / 156;
      endcase
      if (k % 2 == 1) s = s - longint'(term);
      else            s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > (longint'(1) << 30)) s = longint'(1) << 30;
    sq = (longint'(s) * longint'(s) + (64'd1 << 43)) >> 44;
    return sq[AMP_W-1:0];
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int i = 0; i < COS_ENTRIES; i++) rom[i] = cos_weight(i);
    return rom;
  endfunction

endpackage

/* sv/fvn_hash.sv */
// Four-stage pipelined lattice hash: one point in per cycle, value out of the fourth stage.
// Depends on fvn_pkg for the prime tables and the point tag.
module fvn_hash import fvn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    pt_valid,
  input  logic [31:0]             pt_x,
  input  logic [31:0]             pt_y,
  input  logic [SET_W-1:0]        pt_set,
  input  hash_tag_t               pt_tag,
  output logic                    hv_valid,
  output logic signed [VAL_W-1:0] hv_value,
  output hash_tag_t               hv_tag,
  output logic                    busy
);

  logic [3:0]       vld_r;
  logic [31:0]      n1_r, n2_r, n3_r, nn_r, q_r;
  logic [SET_W-1:0] set1_r, set2_r, set3_r;
  hash_tag_t        tag1_r, tag2_r, tag3_r, tag4_r;
  logic signed [VAL_W-1:0] val_r;
  logic [31:0]      n0, n1, t;

  // Mix the coordinates, and finish the polynomial in the last stage.
  always_comb begin
    n0 = pt_x + 32'(pt_y * 32'd57);
    n1 = (n0 << 13) ^ n0;
    t  = 32'(n3_r * q_r) + PRIME_C[set3_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], pt_valid};
    end
  end

  // One multiplication per stage.
  always_ff @(posedge clk) begin
    n1_r   <= n1;
    set1_r <= pt_set;
    tag1_r <= pt_tag;
    nn_r   <= 32'(n1_r * n1_r);
    n2_r   <= n1_r;
    set2_r <= set1_r;
    tag2_r <= tag1_r;
    q_r    <= 32'(nn_r * PRIME_A[set2_r]) + PRIME_B[set2_r];
    n3_r   <= n2_r;
    set3_r <= set2_r;
    tag3_r <= tag2_r;
    val_r  <= $signed(18'd65536) - $signed({1'b0, t[30:14]});
    tag4_r <= tag3_r;
  end

  assign hv_valid = vld_r[3];
  assign hv_value = val_r;
  assign hv_tag   = tag4_r;
  assign busy     = |vld_r;

endmodule

/* sv/fvn_ctrl.sv */
// Controller state machine: sequences octaves, lattice points and blend steps.
// Depends on fvn_pkg; drives the datapath only through dp_cmd_t and reads dp_stat_t.
module fvn_ctrl import fvn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       opcode,
  input  logic [3:0]       table_select,
  input  logic [3:0]       octave_table_base,
  input  logic [3:0]       num_octaves,
  input  dp_stat_t         stat,
  output logic             busy,
  output dp_cmd_t          cmd
);

  ctrl_state_t      state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [OCT_W-1:0] n_r, n_nxt, oct_r, oct_nxt, n_clamp;
  logic [3:0]       nb_r, nb_nxt;
  logic [1:0]       cor_r, cor_nxt;
  logic [SET_W-1:0] sel_set, base_set, oct_set;
  logic             last9, last_pt, fractal;
  nb_info_t         nbi;

  // Prime set selection and octave count limit.
  always_comb begin
    sel_set  = mod_sets({1'b0, table_select});
    base_set = mod_sets({1'b0, octave_table_base});
    oct_set  = mod_sets(5'(base_set) + 5'(oct_r));
    n_clamp  = (num_octaves > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : num_octaves;
    fractal  = (op_r == OPC_FRACTAL);
    nbi      = nb_info(nb_r);
    last9    = (nb_r == 4'd8);
    last_pt  = (op_r == OPC_RAW) || (op_r == OPC_SMOOTH && last9) ||
               (last9 && cor_r == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OPC_RAW;
      n_r     <= '0;
      oct_r   <= '0;
      nb_r    <= '0;
      cor_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      n_r     <= n_nxt;
      oct_r   <= oct_nxt;
      nb_r    <= nb_nxt;
      cor_r   <= cor_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    n_nxt     = n_r;
    oct_nxt   = oct_r;
    nb_nxt    = nb_r;
    cor_nxt   = cor_r;
    cmd       = '0;
    cmd.op    = DP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = DP_LOAD;
          op_nxt    = opcode;
          n_nxt     = n_clamp;
          oct_nxt   = '0;
          state_nxt = (opcode == OPC_FRACTAL && n_clamp == '0) ? S_OUT : S_PREP;
        end
      end
      S_PREP: begin
        cmd.op       = DP_PREP;
        cmd.amp_step = fractal;
        cmd.set      = fractal ? oct_set : sel_set;
        cmd.scale    = fractal ? 3'(n_r - oct_r - OCT_W'(1)) : 3'd0;
        nb_nxt       = '0;
        cor_nxt      = '0;
        state_nxt    = S_ROM;
      end
      S_ROM: begin
        cmd.op    = DP_ROM;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (op_r == OPC_RAW) begin
          cmd.off_x = 3'sd0;
          cmd.off_y = 3'sd0;
          cmd.tag   = '{first: 1'b1, last: 1'b1, corner: 2'd0, shift: 3'd4};
        end else begin
          cmd.off_x = 3'(nbi.dx) + $signed({2'b00, cor_r[0]});
          cmd.off_y = 3'(nbi.dy) + $signed({2'b00, cor_r[1]});
          cmd.tag   = '{first: (nb_r == 4'd0), last: last9, corner: cor_r,
                        shift: nbi.shift};
        end
        nb_nxt = last9 ? 4'd0 : nb_r + 4'd1;
        if (last9) cor_nxt = cor_r + 2'd1;
        if (last_pt) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = (op_r == OPC_RAW || op_r == OPC_SMOOTH) ? S_FINV : S_BLA;
      end
      S_BLA: begin
        cmd.op    = DP_BLA;
        state_nxt = S_BLB;
      end
      S_BLB: begin
        cmd.op    = DP_BLB;
        state_nxt = S_BLC;
      end
      S_BLC: begin
        cmd.op    = DP_BLC;
        state_nxt = S_BLD;
      end
      S_BLD: begin
        cmd.op    = DP_BLD;
        state_nxt = S_BLE;
      end
      S_BLE: begin
        cmd.op    = DP_BLE;
        state_nxt = S_OCTM;
      end
      S_OCTM: begin
        cmd.op    = DP_OCTM;
        state_nxt = S_OCTA;
      end
      S_OCTA: begin
        cmd.op = DP_OCTA;
        if (fractal && (oct_r + OCT_W'(1)) < n_r) begin
          oct_nxt   = oct_r + OCT_W'(1);
          state_nxt = S_PREP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FINV: begin
        cmd.op    = DP_FINV;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.op    = DP_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE) || stat.out_pending;

endmodule

/* sv/fvn_dpath.sv */
// Datapath: coordinate split, weight ROM, hash pipeline, smoothing, blending, octave sum.
// Depends on fvn_pkg and fvn_hash; obeys the commands of fvn_ctrl.
module fvn_dpath import fvn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  input  logic [31:0]             coord_x,
  input  logic [31:0]             coord_y,
  input  logic [AMP_W-1:0]        persistence,
  output dp_stat_t                stat,
  output logic                    noise_valid,
  output logic [OUT_W-1:0]        noise_value
);

  localparam cos_rom_t COS_ROM = build_cos_rom();
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_LIMIT);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;

  logic [31:0]              rx_r, ry_r, ix_r, iy_r;
  logic [COS_IDX_W-1:0]     fx_r, fy_r;
  logic [AMP_W-1:0]         wx_r, wy_r, amp_r, pers_r;
  logic [SET_W-1:0]         set_r;
  logic signed [SMO_W-1:0]  v_r [4];
  logic signed [SMO_W-1:0]  h0_r, h1_r, itp_r;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt, shv;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, sat;
  logic [OUT_W-1:0]         out_r;
  logic                     out_vld_r;
  logic                     hv_valid, hash_busy;
  logic signed [VAL_W-1:0]  hv_value;
  hash_tag_t                hv_tag;
  logic [31:0]              pt_x, pt_y;
  logic signed [SMO_W:0]    diff;
  logic [AMP_W-1:0]         wsel;

  // Lattice point of the current issue.
  assign pt_x = ix_r + 32'(cmd.off_x);
  assign pt_y = iy_r + 32'(cmd.off_y);

  fvn_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .pt_valid (cmd.issue),
    .pt_x     (pt_x),
    .pt_y     (pt_y),
    .pt_set   (set_r),
    .pt_tag   (cmd.tag),
    .hv_valid (hv_valid),
    .hv_value (hv_value),
    .hv_tag   (hv_tag),
    .busy     (hash_busy)
  );

  // Weighted smoothing sum of returning hash values.
  always_comb begin
    shv     = SUM_W'(hv_value) <<< hv_tag.shift;
    sum_nxt = hv_tag.first ? shv : sum_r + shv;
  end

  // Blend difference and weight for the shared multiplier.
  always_comb begin
    unique case (cmd.op)
      DP_BLA:  diff = (SMO_W+1)'(v_r[1]) - (SMO_W+1)'(v_r[0]);
      DP_BLB:  diff = (SMO_W+1)'(v_r[3]) - (SMO_W+1)'(v_r[2]);
      default: diff = (SMO_W+1)'(h1_r) - (SMO_W+1)'(h0_r);
    endcase
    wsel = (cmd.op == DP_BLD) ? wy_r : wx_r;
  end

  // Saturation of the final sum.
  always_comb begin
    if (acc_r > SAT_HI)      sat = SAT_HI;
    else if (acc_r < SAT_LO) sat = SAT_LO;
    else                     sat = acc_r;
  end

  always_ff @(posedge clk) begin
    if (hv_valid) begin
      sum_r <= sum_nxt;
      if (hv_tag.last) v_r[hv_tag.corner] <= SMO_W'(sum_nxt >>> 4);
    end
    unique case (cmd.op)
      DP_LOAD: begin
        rx_r   <= coord_x;
        ry_r   <= coord_y;
        acc_r  <= '0;
        amp_r  <= ONE_Q16;
        pers_r <= (persistence > ONE_Q16) ? ONE_Q16 : persistence;
      end
      DP_PREP: begin
        ix_r  <= split_int(rx_r, cmd.scale);
        iy_r  <= split_int(ry_r, cmd.scale);
        fx_r  <= split_idx(rx_r, cmd.scale);
        fy_r  <= split_idx(ry_r, cmd.scale);
        set_r <= cmd.set;
        if (cmd.amp_step) amp_r <= AMP_W'(((2*AMP_W)'(amp_r) * (2*AMP_W)'(pers_r)) >> 16);
      end
      DP_ROM: begin
        wx_r <= COS_ROM[fx_r];
        wy_r <= COS_ROM[fy_r];
      end
      DP_BLA: prod_r <= PROD_W'(diff) * PROD_W'($signed({1'b0, wsel}));
      DP_BLB: begin
        h0_r   <= SMO_W'(PROD_W'(v_r[0]) + (prod_r >>> 16));
        prod_r <= PROD_W'(diff) * PROD_W'($signed({1'b0, wsel}));
      end
      DP_BLC: h1_r <= SMO_W'(PROD_W'(v_r[2]) + (prod_r >>> 16));
      DP_BLD: prod_r <= PROD_W'(diff) * PROD_W'($signed({1'b0, wsel}));
      DP_BLE: itp_r <= SMO_W'(PROD_W'(h0_r) + (prod_r >>> 16));
      DP_OCTM: prod_r <= PROD_W'(itp_r) * PROD_W'($signed({1'b0, amp_r}));
      DP_OCTA: acc_r <= acc_r + ACC_W'(prod_r >>> 16);
      DP_FINV: acc_r <= ACC_W'(v_r[0]);
      DP_OUT:  out_r <= OUT_W'(sat);
      default: ;
    endcase
  end

  // Result strobe lasts one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= (cmd.op == DP_OUT);
    end
  end

  assign stat.pipe_busy   = hash_busy;
  assign stat.out_pending = 1'b0;
  assign noise_valid      = out_vld_r;
  assign noise_value      = out_r;

endmodule

/* sv/fractal_value_noise_2d.sv */
// Top level of the fractal value noise block: configuration registers and the
// controller and datapath. Depends on fvn_pkg, fvn_ctrl, fvn_dpath and fvn_hash.
//
// Use: hold start high with in_opcode, in_coord_x and in_coord_y; the word is
// taken at the first rising edge where busy is low. One result word follows,
// shown on out_noise_value for exactly one cycle while out_valid is high; the
// receiver cannot stall it and must take it in that cycle.
// Lattice points go one per cycle through the four-stage hash pipeline, and
// interpolated and fractal noise share one blend multiplier. Fractal noise
// makes one pass per octave, at most eight, or none if set to zero octaves.
// One word is in work at a time; busy stays high until the result is shown.
// Registers sit on an APB port at byte addresses 0, 4, 8 and 12; they must be
// written only while the block is idle. Reset (rst_n low, synchronous) returns
// the registers to 0, 0, 7 and 32768 and drops busy and out_valid.
module fractal_value_noise_2d import fvn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_opcode,
  input  logic signed [31:0]      in_coord_x,
  input  logic signed [31:0]      in_coord_y,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_noise_value
);

  logic [3:0]       table_select_r, octave_base_r, num_octaves_r;
  logic [AMP_W-1:0] persistence_r;
  logic             wr_en;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [OUT_W-1:0] noise;

  // Configuration register writes.
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_select_r <= 4'd0;
      octave_base_r  <= 4'd0;
      num_octaves_r  <= 4'd7;
      persistence_r  <= 17'd32768;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_TABLE_SELECT: table_select_r <= pwdata[3:0];
        REG_OCTAVE_BASE:  octave_base_r  <= pwdata[3:0];
        REG_NUM_OCTAVES:  num_octaves_r  <= pwdata[3:0];
        REG_PERSISTENCE:  persistence_r  <= pwdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[3:2])
      REG_TABLE_SELECT: prdata = {28'd0, table_select_r};
      REG_OCTAVE_BASE:  prdata = {28'd0, octave_base_r};
      REG_NUM_OCTAVES:  prdata = {28'd0, num_octaves_r};
      REG_PERSISTENCE:  prdata = {15'd0, persistence_r};
      default:          prdata = '0;
    endcase
  end

  fvn_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .opcode            (in_opcode),
    .table_select      (table_select_r),
    .octave_table_base (octave_base_r),
    .num_octaves       (num_octaves_r),
    .stat              (stat),
    .busy              (busy),
    .cmd               (cmd)
  );

  fvn_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .coord_x     (in_coord_x),
    .coord_y     (in_coord_y),
    .persistence (persistence_r),
    .stat        (stat),
    .noise_valid (out_valid),
    .noise_value (noise)
  );

  assign out_noise_value = $signed(noise);

endmodule

/* sv/fvn_check.sv */
// Port-level checker of the fractal value noise block, bound to the top level.
// Depends on fractal_value_noise_2d_assert.svh for the assertion macros.
`include "fractal_value_noise_2d_assert.svh"

module fvn_check (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic signed [20:0] out_noise_value
);

  // A taken word keeps the block busy in the next cycle.
  `FVN_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

  // The result strobe never stays high: strobes are never back to back.
  `FVN_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held over two cycles")

  // A result ends a busy period.
  `FVN_ASSERT_SAME(a_result_ends_work, out_valid, !busy && $past(busy), "result outside a busy period")

  // Results stay inside the saturation range.
  `FVN_ASSERT_SAME(a_result_range, out_valid, (out_noise_value <= 21'sd524288) && (out_noise_value >= -21'sd524288), "result beyond saturation range")

endmodule

bind fractal_value_noise_2d fvn_check u_fvn_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_noise_value (out_noise_value)
);
